[hw/rtl/kbs_pkg.sv]
// Shared types, codes and the CRC-32 byte step for the keyed blob store.
`timescale 1ns / 1ps
package kbs_pkg;

    localparam int LEN_W = 7;
    localparam int CRC_W = 32;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [2:0] {
        OP_INIT      = 3'd0,
        OP_DEINIT    = 3'd1,
        OP_SAVE      = 3'd2,
        OP_LOAD      = 3'd3,
        OP_ERASE     = 3'd4,
        OP_ERASE_ALL = 3'd5,
        OP_EXISTS    = 3'd6,
        OP_CRC       = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_INIT  = 3'd1,
        ST_INVALID   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CRC_ERR   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SAVE_RD,
        S_SAVE_WR,
        S_SAVE_DONE,
        S_LCHK,
        S_LRD,
        S_LCRC,
        S_LCMP,
        S_ORD,
        S_OUT
    } state_t;

    // One byte through the reflected CRC-32, one bit per step.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[hw/rtl/keyed_blob_store_crc_checked.sv]
// Keyed record store with CRC-32 checked save and load.
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+-------------------
//  command  | op key data_in last_byte max_length                | start & !busy
//  result   | status data_out record_length crc_value exists last| strobe, one cycle
//
// Init, deinit, erase, erase all, exists, crc byte and non-final save bytes answer
// from the dispatch state. A final save byte that passes its checks copies the staged
// record, one staging read and one shared CRC step per byte. A load runs a CRC walk
// then an output walk through the registered record RAM, a read state before each byte.
// Reset clears the service flag, record valid bits and the stream state; the RAMs
// are not cleared. The result side cannot stall; busy holds off new beats.
`timescale 1ns / 1ps
module keyed_blob_store_crc_checked #(
    parameter int KEYS       = 16,
    parameter int BLOB_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [7:0]  key,
    input  logic [7:0]  data_in,
    input  logic        last_byte,
    input  logic [15:0] max_length,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [7:0]  data_out,
    output logic [6:0]  record_length,
    output logic [31:0] crc_value,
    output logic        exists,
    output logic        last
);

    localparam int KW     = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int SW     = (BLOB_BYTES > 1) ? $clog2(BLOB_BYTES) : 1;
    localparam int RDEPTH = KEYS * BLOB_BYTES;
    localparam int AW     = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int MW     = kbs_pkg::LEN_W + kbs_pkg::CRC_W;
    localparam logic [kbs_pkg::LEN_W-1:0] BLOB_LEN = kbs_pkg::LEN_W'(BLOB_BYTES);

    kbs_pkg::state_t state_reg, state_next;

    logic [2:0]  op_reg, op_next;
    logic [7:0]  key_reg, key_next;
    logic [7:0]  din_reg, din_next;
    logic        lastb_reg, lastb_next;
    logic [15:0] maxlen_reg, maxlen_next;

    logic                       svc_reg, svc_next;
    logic [KEYS-1:0]            valid_reg, valid_next;
    logic [kbs_pkg::LEN_W-1:0]  cnt_reg, cnt_next;
    logic                       ovf_reg, ovf_next;
    logic [31:0]                run_crc_reg, run_crc_next;
    logic [kbs_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic [kbs_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [31:0]                wcrc_reg, wcrc_next;
    logic [31:0]                ref_crc_reg, ref_crc_next;
    logic [AW-1:0]              base_reg, base_next;

    logic        strobe_reg, strobe_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  dout_reg, dout_next;
    logic [6:0]  rlen_reg, rlen_next;
    logic [31:0] crcv_reg, crcv_next;
    logic        ex_reg, ex_next;
    logic        last_reg, last_next;

    logic          stg_we;
    logic [7:0]    stg_rdata;
    logic          rec_we;
    logic [7:0]    rec_rdata;
    logic [AW-1:0] rec_addr;
    logic          meta_we;
    logic [MW-1:0] meta_rdata;

    logic [KW-1:0] key_idx;
    logic          kok;
    logic [31:0]   crc_a, crc_out;
    logic [7:0]    crc_b;
    logic [kbs_pkg::LEN_W-1:0] cnt_a, idx_inc;
    logic          ovf_a;
    logic [kbs_pkg::LEN_W-1:0] meta_len;

    assign key_idx  = key_reg[KW-1:0];
    assign kok      = {1'b0, key_reg} < 9'(KEYS);
    assign rec_addr = base_reg + AW'(idx_reg);
    assign idx_inc  = idx_reg + 1'b1;
    assign meta_len = meta_rdata[MW-1:kbs_pkg::CRC_W];

    kbs_ram #(.WIDTH(8), .DEPTH(BLOB_BYTES)) u_stage (
        .clk   (clk),
        .we    (stg_we),
        .waddr (cnt_reg[SW-1:0]),
        .wdata (din_reg),
        .raddr (idx_reg[SW-1:0]),
        .rdata (stg_rdata)
    );

    kbs_ram #(.WIDTH(8), .DEPTH(RDEPTH)) u_rec (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_addr),
        .wdata (stg_rdata),
        .raddr (rec_addr),
        .rdata (rec_rdata)
    );

    kbs_ram #(.WIDTH(MW), .DEPTH(KEYS)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (key_idx),
        .wdata ({len_reg, wcrc_reg}),
        .raddr (key_idx),
        .rdata (meta_rdata)
    );

    // Shared CRC byte unit.
    always_comb
    begin
        if (state_reg == kbs_pkg::S_DISPATCH)
        begin
            crc_a = run_crc_reg;
            crc_b = din_reg;
        end
        else if (state_reg == kbs_pkg::S_SAVE_WR)
        begin
            crc_a = wcrc_reg;
            crc_b = stg_rdata;
        end
        else
        begin
            crc_a = wcrc_reg;
            crc_b = rec_rdata;
        end
        crc_out = kbs_pkg::crc_byte(crc_a, crc_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kbs_pkg::S_IDLE;
            op_reg      <= '0;
            key_reg     <= '0;
            din_reg     <= '0;
            lastb_reg   <= 1'b0;
            maxlen_reg  <= '0;
            svc_reg     <= 1'b0;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            run_crc_reg <= kbs_pkg::CRC_INIT;
            idx_reg     <= '0;
            len_reg     <= '0;
            wcrc_reg    <= kbs_pkg::CRC_INIT;
            ref_crc_reg <= '0;
            base_reg    <= '0;
            strobe_reg  <= 1'b0;
            status_reg  <= '0;
            dout_reg    <= '0;
            rlen_reg    <= '0;
            crcv_reg    <= '0;
            ex_reg      <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            key_reg     <= key_next;
            din_reg     <= din_next;
            lastb_reg   <= lastb_next;
            maxlen_reg  <= maxlen_next;
            svc_reg     <= svc_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            run_crc_reg <= run_crc_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            wcrc_reg    <= wcrc_next;
            ref_crc_reg <= ref_crc_next;
            base_reg    <= base_next;
            strobe_reg  <= strobe_next;
            status_reg  <= status_next;
            dout_reg    <= dout_next;
            rlen_reg    <= rlen_next;
            crcv_reg    <= crcv_next;
            ex_reg      <= ex_next;
            last_reg    <= last_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        din_next     = din_reg;
        lastb_next   = lastb_reg;
        maxlen_next  = maxlen_reg;
        svc_next     = svc_reg;
        valid_next   = valid_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        run_crc_next = run_crc_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        wcrc_next    = wcrc_reg;
        ref_crc_next = ref_crc_reg;
        base_next    = base_reg;
        strobe_next  = 1'b0;
        status_next  = kbs_pkg::ST_OK;
        dout_next    = '0;
        rlen_next    = '0;
        crcv_next    = '0;
        ex_next      = 1'b0;
        last_next    = 1'b0;
        stg_we       = 1'b0;
        rec_we       = 1'b0;
        meta_we      = 1'b0;
        cnt_a        = (cnt_reg < BLOB_LEN) ? cnt_reg + 1'b1 : cnt_reg;
        ovf_a        = (cnt_reg < BLOB_LEN) ? ovf_reg : 1'b1;

        unique case (state_reg)
            kbs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    key_next    = key;
                    din_next    = data_in;
                    lastb_next  = last_byte;
                    maxlen_next = max_length;
                    state_next  = kbs_pkg::S_DISPATCH;
                end
            end
            kbs_pkg::S_DISPATCH:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                state_next  = kbs_pkg::S_IDLE;
                base_next   = AW'(32'(key_idx) * BLOB_BYTES);
                unique case (kbs_pkg::op_t'(op_reg))
                    kbs_pkg::OP_INIT:
                    begin
                        svc_next   = 1'b1;
                        valid_next = '0;
                    end
                    kbs_pkg::OP_DEINIT:
                        svc_next = 1'b0;
                    kbs_pkg::OP_SAVE:
                    begin
                        stg_we   = cnt_reg < BLOB_LEN;
                        cnt_next = cnt_a;
                        ovf_next = ovf_a;
                        if (lastb_reg)
                        begin
                            if (!svc_reg || !kok || ovf_a)
                            begin
                                status_next  = !svc_reg ? kbs_pkg::ST_NOT_INIT
                                                        : kbs_pkg::ST_INVALID;
                                cnt_next     = '0;
                                ovf_next     = 1'b0;
                                run_crc_next = kbs_pkg::CRC_INIT;
                            end
                            else
                            begin
                                // Copy the staged bytes out; answer at the end.
                                strobe_next = 1'b0;
                                last_next   = 1'b0;
                                len_next    = cnt_a;
                                idx_next    = '0;
                                wcrc_next   = kbs_pkg::CRC_INIT;
                                state_next  = kbs_pkg::S_SAVE_RD;
                            end
                        end
                    end
                    kbs_pkg::OP_LOAD:
                    begin
                        if (!svc_reg)
                            status_next = kbs_pkg::ST_NOT_INIT;
                        else if (!kok)
                            status_next = kbs_pkg::ST_INVALID;
                        else
                        begin
                            strobe_next = 1'b0;
                            last_next   = 1'b0;
                            state_next  = kbs_pkg::S_LCHK;
                        end
                    end
                    kbs_pkg::OP_ERASE:
                    begin
                        if (!svc_reg)
                            status_next = kbs_pkg::ST_NOT_INIT;
                        else if (!kok)
                            status_next = kbs_pkg::ST_INVALID;
                        else
                            valid_next[key_idx] = 1'b0;
                    end
                    kbs_pkg::OP_ERASE_ALL:
                    begin
                        if (!svc_reg)
                            status_next = kbs_pkg::ST_NOT_INIT;
                        else
                            valid_next = '0;
                    end
                    kbs_pkg::OP_EXISTS:
                    begin
                        if (!kok)
                            status_next = kbs_pkg::ST_INVALID;
                        else
                            ex_next = valid_reg[key_idx];
                    end
                    kbs_pkg::OP_CRC:
                    begin
                        run_crc_next = crc_out;
                        if (lastb_reg)
                        begin
                            crcv_next    = crc_out;
                            run_crc_next = kbs_pkg::CRC_INIT;
                        end
                    end
                    default:
                        state_next = kbs_pkg::S_IDLE;
                endcase
            end
            kbs_pkg::S_SAVE_RD:
                state_next = kbs_pkg::S_SAVE_WR;
            kbs_pkg::S_SAVE_WR:
            begin
                rec_we    = 1'b1;
                wcrc_next = crc_out;
                idx_next  = idx_inc;
                state_next = (idx_inc == len_reg) ? kbs_pkg::S_SAVE_DONE
                                                  : kbs_pkg::S_SAVE_RD;
            end
            kbs_pkg::S_SAVE_DONE:
            begin
                meta_we             = 1'b1;
                valid_next[key_idx] = 1'b1;
                cnt_next            = '0;
                ovf_next            = 1'b0;
                run_crc_next        = kbs_pkg::CRC_INIT;
                strobe_next         = 1'b1;
                last_next           = 1'b1;
                state_next          = kbs_pkg::S_IDLE;
            end
            kbs_pkg::S_LCHK:
            begin
                if (!valid_reg[key_idx] || 16'(meta_len) > maxlen_reg)
                begin
                    status_next = !valid_reg[key_idx] ? kbs_pkg::ST_NOT_FOUND
                                                      : kbs_pkg::ST_INVALID;
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    state_next  = kbs_pkg::S_IDLE;
                end
                else
                begin
                    len_next     = meta_len;
                    ref_crc_next = meta_rdata[kbs_pkg::CRC_W-1:0];
                    wcrc_next    = kbs_pkg::CRC_INIT;
                    idx_next     = '0;
                    state_next   = (meta_len == '0) ? kbs_pkg::S_LCMP : kbs_pkg::S_LRD;
                end
            end
            kbs_pkg::S_LRD:
                state_next = kbs_pkg::S_LCRC;
            kbs_pkg::S_LCRC:
            begin
                wcrc_next  = crc_out;
                idx_next   = idx_inc;
                state_next = (idx_inc == len_reg) ? kbs_pkg::S_LCMP : kbs_pkg::S_LRD;
            end
            kbs_pkg::S_LCMP:
            begin
                idx_next = '0;
                if (wcrc_reg != ref_crc_reg || len_reg == '0)
                begin
                    status_next = (wcrc_reg != ref_crc_reg) ? kbs_pkg::ST_CRC_ERR
                                                            : kbs_pkg::ST_OK;
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    state_next  = kbs_pkg::S_IDLE;
                end
                else
                    state_next = kbs_pkg::S_ORD;
            end
            kbs_pkg::S_ORD:
                state_next = kbs_pkg::S_OUT;
            kbs_pkg::S_OUT:
            begin
                strobe_next = 1'b1;
                dout_next   = rec_rdata;
                rlen_next   = len_reg;
                last_next   = idx_inc == len_reg;
                idx_next    = idx_inc;
                state_next  = (idx_inc == len_reg) ? kbs_pkg::S_IDLE : kbs_pkg::S_ORD;
            end
            default:
                state_next = kbs_pkg::S_IDLE;
        endcase
    end

    assign busy          = state_reg != kbs_pkg::S_IDLE;
    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign data_out      = dout_reg;
    assign record_length = rlen_reg;
    assign crc_value     = crcv_reg;
    assign exists        = ex_reg;
    assign last          = last_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != kbs_pkg::ST_OK |-> last && data_out == '0)
        else $error("error result not a single final beat");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= BLOB_LEN)
        else $error("stream count beyond blob size");

    a_save_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kbs_pkg::S_SAVE_DONE |=> strobe && valid_reg[$past(key_idx)])
        else $error("save did not mark record valid");

endmodule

[hw/rtl/kbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[bench/keyed_blob_store_crc_checked_test.sv]
// Self-checking bench for the keyed blob store: directed and random command beats.
`timescale 1ns / 1ps
module keyed_blob_store_crc_checked_test;

    localparam int NKEYS = 16;
    localparam int BLOB  = 64;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_out;
        logic [6:0]  record_length;
        logic [31:0] crc_value;
        logic        exists;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [7:0]  key;
    logic [7:0]  data_in;
    logic        last_byte;
    logic [15:0] max_length;
    logic        strobe;
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic [6:0]  record_length;
    logic [31:0] crc_value;
    logic        exists;
    logic        last;

    keyed_blob_store_crc_checked u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .key(key),
        .data_in(data_in), .last_byte(last_byte), .max_length(max_length),
        .strobe(strobe), .status(status), .data_out(data_out),
        .record_length(record_length), .crc_value(crc_value), .exists(exists),
        .last(last)
    );

    // store image kept by the bench
    logic        ready_q;
    logic        valid_q [NKEYS];
    logic [6:0]  len_q [NKEYS];
    logic [31:0] crc_q [NKEYS];
    logic [7:0]  bytes_q [NKEYS][BLOB];
    logic [7:0]  stage_q [BLOB];
    int          stage_cnt;
    logic        stage_ovf;
    logic [31:0] stream_crc;

    result_t     pending_results [$];
    int          mismatches;
    int          send_idle_pct;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ kbs_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic result_t mk(logic [2:0] st, logic [7:0] d, logic [6:0] l,
                                   logic [31:0] c, logic e, logic lst);
        result_t r;
        r = '{st, d, l, c, e, lst};
        return r;
    endfunction

    task automatic push_single(kbs_pkg::status_t st, logic [31:0] c, logic e);
        pending_results.push_back(mk(st, 8'd0, 7'd0, c, e, 1'b1));
    endtask

    task automatic clear_store();
        for (int k = 0; k < NKEYS; k++)
        begin
            valid_q[k] = 1'b0;
            len_q[k] = '0;
            crc_q[k] = '0;
        end
    endtask

    task automatic predict_store(kbs_pkg::op_t o, logic [7:0] k, logic [7:0] d, logic lb,
                                 logic [15:0] ml);
        logic [31:0] c;
        int          n;
        logic        kok;
        kok = k < NKEYS;
        case (o)
            kbs_pkg::OP_INIT:
            begin
                ready_q = 1'b1;
                clear_store();
                push_single(kbs_pkg::ST_OK, 32'd0, 1'b0);
            end
            kbs_pkg::OP_DEINIT:
            begin
                ready_q = 1'b0;
                push_single(kbs_pkg::ST_OK, 32'd0, 1'b0);
            end
            kbs_pkg::OP_SAVE:
            begin
                if (stage_cnt < BLOB)
                begin
                    stage_q[stage_cnt] = d;
                    stage_cnt++;
                end
                else
                    stage_ovf = 1'b1;
                if (!lb)
                    push_single(kbs_pkg::ST_OK, 32'd0, 1'b0);
                else
                begin
                    if (!ready_q)
                        push_single(kbs_pkg::ST_NOT_INIT, 32'd0, 1'b0);
                    else if (!kok || stage_ovf)
                        push_single(kbs_pkg::ST_INVALID, 32'd0, 1'b0);
                    else
                    begin
                        c = kbs_pkg::CRC_INIT;
                        for (int i = 0; i < stage_cnt; i++)
                        begin
                            bytes_q[k][i] = stage_q[i];
                            c = crc_step(c, stage_q[i]);
                        end
                        len_q[k] = stage_cnt[6:0];
                        crc_q[k] = c;
                        valid_q[k] = 1'b1;
                        push_single(kbs_pkg::ST_OK, 32'd0, 1'b0);
                    end
                    stage_cnt = 0;
                    stage_ovf = 1'b0;
                    stream_crc = kbs_pkg::CRC_INIT;
                end
            end
            kbs_pkg::OP_LOAD:
            begin
                if (!ready_q)
                    push_single(kbs_pkg::ST_NOT_INIT, 32'd0, 1'b0);
                else if (!kok)
                    push_single(kbs_pkg::ST_INVALID, 32'd0, 1'b0);
                else if (!valid_q[k])
                    push_single(kbs_pkg::ST_NOT_FOUND, 32'd0, 1'b0);
                else if (16'(len_q[k]) > ml)
                    push_single(kbs_pkg::ST_INVALID, 32'd0, 1'b0);
                else
                begin
                    n = int'(len_q[k]);
                    c = kbs_pkg::CRC_INIT;
                    for (int i = 0; i < n; i++)
                        c = crc_step(c, bytes_q[k][i]);
                    if (c != crc_q[k])
                        push_single(kbs_pkg::ST_CRC_ERR, 32'd0, 1'b0);
                    else if (n == 0)
                        push_single(kbs_pkg::ST_OK, 32'd0, 1'b0);
                    else
                        for (int i = 0; i < n; i++)
                            pending_results.push_back(mk(kbs_pkg::ST_OK, bytes_q[k][i],
                                                         n[6:0], 32'd0, 1'b0,
                                                         i == n - 1));
                end
            end
            kbs_pkg::OP_ERASE:
            begin
                if (!ready_q)
                    push_single(kbs_pkg::ST_NOT_INIT, 32'd0, 1'b0);
                else if (!kok)
                    push_single(kbs_pkg::ST_INVALID, 32'd0, 1'b0);
                else
                begin
                    valid_q[k] = 1'b0;
                    len_q[k] = '0;
                    crc_q[k] = '0;
                    push_single(kbs_pkg::ST_OK, 32'd0, 1'b0);
                end
            end
            kbs_pkg::OP_ERASE_ALL:
            begin
                if (!ready_q)
                    push_single(kbs_pkg::ST_NOT_INIT, 32'd0, 1'b0);
                else
                begin
                    clear_store();
                    push_single(kbs_pkg::ST_OK, 32'd0, 1'b0);
                end
            end
            kbs_pkg::OP_EXISTS:
            begin
                if (!kok)
                    push_single(kbs_pkg::ST_INVALID, 32'd0, 1'b0);
                else
                    push_single(kbs_pkg::ST_OK, 32'd0, valid_q[k]);
            end
            default:
            begin
                stream_crc = crc_step(stream_crc, d);
                if (!lb)
                    push_single(kbs_pkg::ST_OK, 32'd0, 1'b0);
                else
                begin
                    push_single(kbs_pkg::ST_OK, stream_crc, 1'b0);
                    stream_crc = kbs_pkg::CRC_INIT;
                end
            end
        endcase
    endtask

    // Drive one command beat and hold it until accepted; start drops only while idling.
    task automatic send_cmd(kbs_pkg::op_t o, logic [7:0] k, logic [7:0] d, logic lb,
                            logic [15:0] ml);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        key <= k;
        data_in <= d;
        last_byte <= lb;
        max_length <= ml;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_store(o, k, d, lb, ml);
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && strobe)
        begin
            got = '{status, data_out, record_length, crc_value, exists, last};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic save_blob(logic [7:0] k, int n);
        for (int i = 0; i < n; i++)
            send_cmd(kbs_pkg::OP_SAVE, k, 8'($urandom_range(255)), i == n - 1, 16'd0);
    endtask

    task automatic test_directed();
        send_cmd(kbs_pkg::OP_LOAD, 8'd0, 8'd0, 1'b0, 16'hFFFF);      // not initialized
        send_cmd(kbs_pkg::OP_ERASE, 8'd0, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_ERASE_ALL, 8'd0, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_EXISTS, 8'd255, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_EXISTS, 8'd3, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_SAVE, 8'd1, 8'hFF, 1'b1, 16'd0);        // save before init
        send_cmd(kbs_pkg::OP_INIT, 8'd0, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_SAVE, 8'd0, 8'h00, 1'b1, 16'd0);
        send_cmd(kbs_pkg::OP_SAVE, 8'd15, 8'hFF, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_SAVE, 8'd15, 8'hA5, 1'b1, 16'd0);
        send_cmd(kbs_pkg::OP_LOAD, 8'd15, 8'd0, 1'b0, 16'hFFFF);
        send_cmd(kbs_pkg::OP_LOAD, 8'd15, 8'd0, 1'b0, 16'd1);        // too long for buffer
        send_cmd(kbs_pkg::OP_LOAD, 8'd16, 8'd0, 1'b0, 16'hFFFF);
        send_cmd(kbs_pkg::OP_LOAD, 8'd7, 8'd0, 1'b0, 16'hFFFF);      // not found
        send_cmd(kbs_pkg::OP_SAVE, 8'd200, 8'h11, 1'b1, 16'd0);      // bad key
        send_cmd(kbs_pkg::OP_EXISTS, 8'd15, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_ERASE, 8'd255, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_ERASE, 8'd15, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_CRC, 8'd0, 8'h31, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_CRC, 8'd0, 8'hFF, 1'b1, 16'd0);
        send_cmd(kbs_pkg::OP_ERASE_ALL, 8'd0, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_DEINIT, 8'd0, 8'd0, 1'b0, 16'd0);
        send_cmd(kbs_pkg::OP_INIT, 8'd0, 8'd0, 1'b0, 16'd0);
    endtask

    task automatic test_full_and_overflow();
        save_blob(8'd6, BLOB + 1);                 // fills staging, then overflows
        send_cmd(kbs_pkg::OP_EXISTS, 8'd6, 8'd0, 1'b0, 16'd0);
    endtask

    task automatic test_random(int items);
        int r;
        for (int n = 0; n < items; n++)
        begin
            r = int'($urandom_range(99));
            if (r < 35)
                save_blob(8'($urandom_range(17)), int'($urandom_range(1, 6)));
            else if (r < 60)
                send_cmd(kbs_pkg::OP_LOAD, 8'($urandom_range(17)), 8'd0, 1'b0,
                         ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8)));
            else if (r < 75)
                send_cmd(kbs_pkg::OP_CRC, 8'($urandom), 8'($urandom),
                         1'($urandom_range(1)), 16'($urandom));
            else if (r < 78)
                send_cmd(kbs_pkg::OP_DEINIT, 8'($urandom), 8'($urandom),
                         1'($urandom), 16'($urandom));
            else if (r < 83)
                send_cmd(kbs_pkg::OP_INIT, 8'($urandom), 8'($urandom),
                         1'($urandom), 16'($urandom));
            else
                send_cmd(kbs_pkg::op_t'(3'($urandom_range(7))), 8'($urandom_range(20)),
                         8'($urandom), 1'($urandom_range(1)), 16'($urandom));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = kbs_pkg::OP_INIT;
        key = '0;
        data_in = '0;
        last_byte = 1'b0;
        max_length = '0;
        mismatches = 0;
        send_idle_pct = 25;
        ready_q = 1'b0;
        clear_store();
        stage_cnt = 0;
        stage_ovf = 1'b0;
        stream_crc = kbs_pkg::CRC_INIT;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_and_overflow();
        test_random(8);
        send_idle_pct = 87;
        test_random(7);
        send_idle_pct = 0;
        test_random(8);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

[files.f]
hw/rtl/kbs_pkg.sv
hw/rtl/kbs_ram.sv
hw/rtl/keyed_blob_store_crc_checked.sv
bench/keyed_blob_store_crc_checked_test.sv
